>>> src/sample_trend_classifier_macros.svh
// Assertion helpers for the trend classifier.
// STC_ASSERT_IMP: same-cycle implication. STC_ASSERT_NXT: next-cycle implication.
`ifndef SAMPLE_TREND_CLASSIFIER_MACROS_SVH
`define SAMPLE_TREND_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define STC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trend classifier check failed");

`define STC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trend classifier check failed");

`else

`define STC_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define STC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> src/stc_pkg.sv
package stc_pkg;

  // Field widths
  localparam int SAMPLE_W   = 40;
  localparam int THRESH_W   = 20;
  localparam int MINS_W     = 5;
  localparam int FILL_OUT_W = 5;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 2;

  // Register reset values and limits
  localparam logic [THRESH_W-1:0] THRESH_RST = 20'd1024;
  localparam logic [MINS_W-1:0]   MINS_RST   = 5'd5;
  localparam logic [MINS_W-1:0]   MINS_FLOOR = 5'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES      = 2'd1;

  // Trend codes
  typedef enum logic [CLASS_W-1:0] {
    CLS_UNKNOWN   = 2'd0,
    CLS_STABLE    = 2'd1,
    CLS_GROWING   = 2'd2,
    CLS_DECLINING = 2'd3
  } trend_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC,
    ST_PROD,
    ST_DIFF,
    ST_LIM,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic store;      // push sample into ring
    logic acc_start;  // clear sums, point at oldest sample
    logic acc_run;    // issue reads and accumulate
    logic prod;       // register cross products
    logic diff;       // form num and den
    logic lim;        // form |num| and threshold*den
    logic load_out;   // capture result word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enough;     // window holds enough samples to classify
    logic acc_done;   // last sample accumulated this cycle
  } stat_t;

endpackage

>>> src/stc_ctrl.sv
`include "sample_trend_classifier_macros.svh"

module stc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  stc_pkg::stat_t stat,
  output stc_pkg::cmd_t  cmd
);
  import stc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_go;

  // output register free or being emptied
  assign fin_go = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = stat.enough ? ST_ACC : ST_FIN;
      ST_ACC:   if (stat.acc_done) state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_LIM;
      ST_LIM:   state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.store = in_valid;
      end
      ST_CHECK: cmd.acc_start = stat.enough;
      ST_ACC:   cmd.acc_run = 1'b1;
      ST_PROD:  cmd.prod = 1'b1;
      ST_DIFF:  cmd.diff = 1'b1;
      ST_LIM:   cmd.lim = 1'b1;
      ST_FIN:   cmd.load_out = fin_go;
      default:  cmd = '0;
    endcase
  end

  // result word valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `STC_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_r == ST_CHECK)
  `STC_ASSERT_NXT(a_fin_loads, clk, rst_n, state_r == ST_FIN && fin_go, out_valid_r && state_r == ST_IDLE)
  `STC_ASSERT_NXT(a_acc_holds, clk, rst_n, state_r == ST_ACC && !stat.acc_done, state_r == ST_ACC)
  `STC_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

>>> src/stc_dp.sv
`include "sample_trend_classifier_macros.svh"

module stc_dp #(
  parameter int WINDOW = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stc_pkg::cmd_t                  cmd,
  output stc_pkg::stat_t                 stat,
  input  logic                           cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stc_pkg::THRESH_W-1:0]   cfg_data,
  input  logic [stc_pkg::SAMPLE_W-1:0]   in_sample,
  output logic [stc_pkg::CLASS_W-1:0]    out_class,
  output logic [stc_pkg::FILL_OUT_W-1:0] out_fill
);
  import stc_pkg::*;

  localparam int CW     = $clog2(WINDOW + 1);   // sample count
  localparam int IW     = $clog2(WINDOW);       // ring slot / position
  localparam int SY_W   = SAMPLE_W + CW;
  localparam int SXY_W  = SAMPLE_W + IW + CW;
  localparam int SX_W   = IW + CW;
  localparam int SXX_W  = 2 * IW + CW;
  localparam int IY_W   = IW + SAMPLE_W;
  localparam int SQ_W   = 2 * IW;
  localparam int PRD_W  = SAMPLE_W + IW + 2 * CW;
  localparam int DEN_W  = 2 * IW + 2 * CW;
  localparam int LIM_W  = THRESH_W + DEN_W;
  localparam int CMP_W  = (PRD_W > LIM_W) ? PRD_W : LIM_W;
  localparam int NC_W   = (CW > MINS_W) ? CW : MINS_W;
  localparam logic [CW-1:0] FILL_MAX  = CW'(WINDOW);
  localparam logic [IW-1:0] SLOT_LAST = IW'(WINDOW - 1);

  // sample ring
  logic [SAMPLE_W-1:0] ring [WINDOW];
  logic [SAMPLE_W-1:0] rdata_r;

  // control state
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [THRESH_W-1:0] thr_r, thr_nxt;
  logic [MINS_W-1:0]   mins_r, mins_nxt;
  logic [IW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                rd_vld_r, rd_vld_nxt;

  // payload
  logic [IW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [SY_W-1:0]        sy_r, sy_nxt;
  logic [SXY_W-1:0]       sxy_r, sxy_nxt;
  logic [SX_W-1:0]        sx_r, sx_nxt;
  logic [SXX_W-1:0]       sxx_r, sxx_nxt;
  logic [PRD_W-1:0]       nsxy_r, nsxy_nxt;
  logic [PRD_W-1:0]       sxsy_r, sxsy_nxt;
  logic [DEN_W-1:0]       nsxx_r, nsxx_nxt;
  logic [DEN_W-1:0]       sxsx_r, sxsx_nxt;
  logic signed [PRD_W:0]  num_r, num_nxt;
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic [PRD_W-1:0]       mag_r, mag_nxt;
  logic [LIM_W-1:0]       limit_r, limit_nxt;
  logic                   num_pos_r, num_pos_nxt;
  logic [CLASS_W-1:0]     class_r, class_nxt;
  logic [FILL_OUT_W-1:0]  ofill_r, ofill_nxt;

  logic [MINS_W-1:0] need;
  logic [IW-1:0]     oldest;
  logic [IY_W-1:0]   idx_y;
  logic [SQ_W-1:0]   idx_sq;
  logic signed [PRD_W:0] num_neg;

  // status
  assign need   = (mins_r < MINS_FLOOR) ? MINS_FLOOR : mins_r;
  assign stat.enough   = NC_W'(fill_r) >= NC_W'(need);
  assign stat.acc_done = rd_vld_r && (CW'(rd_idx_r) == fill_r - CW'(1));

  // until the ring wraps the oldest sample sits in slot zero
  assign oldest = (fill_r == FILL_MAX) ? slot_r : '0;

  // per-sample terms
  assign idx_y  = IY_W'(rd_idx_r) * IY_W'(rdata_r);
  assign idx_sq = SQ_W'(rd_idx_r) * SQ_W'(rd_idx_r);
  assign num_neg = -num_r;

  always_comb begin
    slot_nxt    = slot_r;
    fill_nxt    = fill_r;
    thr_nxt     = thr_r;
    mins_nxt    = mins_r;
    rd_ptr_nxt  = rd_ptr_r;
    iss_nxt     = iss_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    sy_nxt      = sy_r;
    sxy_nxt     = sxy_r;
    sx_nxt      = sx_r;
    sxx_nxt     = sxx_r;
    nsxy_nxt    = nsxy_r;
    sxsy_nxt    = sxsy_r;
    nsxx_nxt    = nsxx_r;
    sxsx_nxt    = sxsx_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    mag_nxt     = mag_r;
    limit_nxt   = limit_r;
    num_pos_nxt = num_pos_r;
    class_nxt   = class_r;
    ofill_nxt   = ofill_r;

    // register writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STABLE_THRESHOLD: thr_nxt = cfg_data;
        CFG_MIN_SAMPLES:      mins_nxt = cfg_data[MINS_W-1:0];
        default: ;
      endcase
    end

    // ring pointer wraps, fill saturating
    if (cmd.store) begin
      slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + IW'(1);
      fill_nxt = (fill_r == FILL_MAX) ? fill_r : fill_r + CW'(1);
    end

    // accumulation pass, oldest to newest
    if (cmd.acc_start) begin
      rd_ptr_nxt = oldest;
      iss_nxt    = '0;
      sy_nxt     = '0;
      sxy_nxt    = '0;
      sx_nxt     = '0;
      sxx_nxt    = '0;
    end else if (cmd.acc_run) begin
      if (iss_r != fill_r) begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = iss_r[IW-1:0];
        iss_nxt    = iss_r + CW'(1);
        rd_ptr_nxt = (rd_ptr_r == SLOT_LAST) ? '0 : rd_ptr_r + IW'(1);
      end
      if (rd_vld_r) begin
        sy_nxt  = sy_r + SY_W'(rdata_r);
        sxy_nxt = sxy_r + SXY_W'(idx_y);
        sx_nxt  = sx_r + SX_W'(rd_idx_r);
        sxx_nxt = sxx_r + SXX_W'(idx_sq);
      end
    end

    // cross products
    if (cmd.prod) begin
      nsxy_nxt = PRD_W'(fill_r) * PRD_W'(sxy_r);
      sxsy_nxt = PRD_W'(sx_r) * PRD_W'(sy_r);
      nsxx_nxt = DEN_W'(fill_r) * DEN_W'(sxx_r);
      sxsx_nxt = DEN_W'(sx_r) * DEN_W'(sx_r);
    end

    // slope numerator and denominator
    if (cmd.diff) begin
      num_nxt = $signed({1'b0, nsxy_r}) - $signed({1'b0, sxsy_r});
      den_nxt = nsxx_r - sxsx_r;
    end

    // magnitude and stability limit
    if (cmd.lim) begin
      mag_nxt     = num_r[PRD_W] ? num_neg[PRD_W-1:0] : num_r[PRD_W-1:0];
      limit_nxt   = LIM_W'(thr_r) * LIM_W'(den_r);
      num_pos_nxt = !num_r[PRD_W] && (num_r != '0);
    end

    // result word
    if (cmd.load_out) begin
      if (!stat.enough) begin
        class_nxt = CLS_UNKNOWN;
      end else if (CMP_W'(mag_r) < CMP_W'(limit_r)) begin
        class_nxt = CLS_STABLE;
      end else if (num_pos_r) begin
        class_nxt = CLS_GROWING;
      end else begin
        class_nxt = CLS_DECLINING;
      end
      ofill_nxt = FILL_OUT_W'(fill_r);
    end
  end

  // ring write and registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[slot_r] <= in_sample;
    end
    rdata_r <= ring[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      thr_r    <= THRESH_RST;
      mins_r   <= MINS_RST;
      rd_vld_r <= 1'b0;
    end else begin
      slot_r   <= slot_nxt;
      fill_r   <= fill_nxt;
      thr_r    <= thr_nxt;
      mins_r   <= mins_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r  <= rd_ptr_nxt;
    iss_r     <= iss_nxt;
    rd_idx_r  <= rd_idx_nxt;
    sy_r      <= sy_nxt;
    sxy_r     <= sxy_nxt;
    sx_r      <= sx_nxt;
    sxx_r     <= sxx_nxt;
    nsxy_r    <= nsxy_nxt;
    sxsy_r    <= sxsy_nxt;
    nsxx_r    <= nsxx_nxt;
    sxsx_r    <= sxsx_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    mag_r     <= mag_nxt;
    limit_r   <= limit_nxt;
    num_pos_r <= num_pos_nxt;
    class_r   <= class_nxt;
    ofill_r   <= ofill_nxt;
  end

  assign out_class = class_r;
  assign out_fill  = ofill_r;

  // checks
  `STC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_MAX)
  `STC_ASSERT_IMP(a_slot_tracks_fill, clk, rst_n, fill_r != FILL_MAX, CW'(slot_r) == fill_r)
  `STC_ASSERT_IMP(a_read_in_window, clk, rst_n, rd_vld_r, CW'(rd_idx_r) < fill_r)

endmodule

>>> src/sample_trend_classifier.sv
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_stall   in_usage_sample
// out      output     out_valid / out_stall out_trend_class, out_window_fill
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word at a time: a new word is taken only once the last result is loaded,
// and the accumulation pass over the held samples is skipped when the class is unknown.
// The pace is set by the accumulation pass: one ring read per cycle.
// Synchronous active-low reset clears the ring pointer and fill count and sets the registers to their defaults.
// A result held under out_stall does not block the next input word.
module sample_trend_classifier #(
  parameter int WINDOW = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [stc_pkg::SAMPLE_W-1:0]   in_usage_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [stc_pkg::CLASS_W-1:0]    out_trend_class,
  output logic [stc_pkg::FILL_OUT_W-1:0] out_window_fill,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stc_pkg::THRESH_W-1:0]   cfg_data
);
  import stc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  stc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  stc_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_usage_sample),
    .out_class (out_trend_class),
    .out_fill  (out_window_fill)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;
  import stc_pkg::*;

  localparam int WIN = 20;
  localparam longint SAMPLE_MAX = 64'h0000_00FF_FFFF_FFFF;
  localparam int SEG_COUNT = 9;
  localparam int SEG_WORDS = 59;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;
  typedef enum int {PAT_NOISE, PAT_LINE, PAT_FLAT, PAT_EDGES} pattern_t;

  typedef struct packed {
    trend_t              cls;
    logic [FILL_OUT_W-1:0] fill;
  } trend_word_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [SAMPLE_W-1:0]   value;
    logic                  typed;
    trend_word_t           word;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_usage_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [CLASS_W-1:0]    out_trend_class;
  logic [FILL_OUT_W-1:0] out_window_fill;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [THRESH_W-1:0]   cfg_data;

  sample_trend_classifier #(.WINDOW(WIN)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_usage_sample (in_usage_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_trend_class (out_trend_class),
    .out_window_fill (out_window_fill),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Shadow copy of the window and registers
  logic [SAMPLE_W-1:0] ring_q [WIN];
  int                  slot_q;
  int                  fill_q;
  logic [THRESH_W-1:0] thr_q;
  logic [MINS_W-1:0]   min_q;

  trend_word_t trend_expect_q[$];
  dir_row_t    dir_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_cnt;
  int sent_cnt;
  int cfg_cnt;
  int class_seen [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Push one sample into the shadow window and classify the slope exactly
  function automatic trend_t trend_push(input logic [SAMPLE_W-1:0] smp);
    int                 need;
    int                 oldest;
    logic signed [71:0] y, sx, sy, sxy, sxx, num, den, mag, lim;
    ring_q[slot_q] = smp;
    slot_q = (slot_q + 1) % WIN;
    if (fill_q < WIN) fill_q++;
    need = (min_q < MINS_FLOOR) ? int'(MINS_FLOOR) : int'(min_q);
    if (fill_q < need) return CLS_UNKNOWN;
    oldest = (slot_q + WIN - fill_q) % WIN;
    sx = 0; sy = 0; sxy = 0; sxx = 0;
    for (int i = 0; i < fill_q; i++) begin
      y = $signed({32'd0, ring_q[(oldest + i) % WIN]});
      sx += i;
      sy += y;
      sxy += y * i;
      sxx += i * i;
    end
    num = fill_q * sxy - sx * sy;
    den = fill_q * sxx - sx * sx;
    mag = (num < 0) ? -num : num;
    lim = $signed({52'd0, thr_q}) * den;
    if (mag < lim) return CLS_STABLE;
    if (num > 0) return CLS_GROWING;
    return CLS_DECLINING;
  endfunction

  // Offer one sample word; record its expected result once accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input trend_word_t typed_word);
    trend_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_usage_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w.cls  = trend_push(smp);
    w.fill = fill_q[FILL_OUT_W-1:0];
    if (typed) w = typed_word;
    trend_expect_q = {trend_expect_q, w};
    sent_cnt++;
  endtask

  // Hold the input off until every result is back and the block is quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (trend_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THRESH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_STABLE_THRESHOLD) thr_q = data;
    else if (idx == CFG_MIN_SAMPLES) min_q = data[MINS_W-1:0];
    cfg_cnt++;
    @(posedge clk);
  endtask

  function automatic void add_sample(input logic [SAMPLE_W-1:0] v, input logic typed,
                                     input trend_t cls, input logic [FILL_OUT_W-1:0] fill);
    dir_row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_idx = '0;
    r.value = v;
    r.typed = typed;
    r.word.cls = cls;
    r.word.fill = fill;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [THRESH_W-1:0] data);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = {20'd0, data};
    r.typed = 1'b0;
    r.word = '0;
    dir_rows = {dir_rows, r};
  endfunction

  // Result side: random stall, compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    trend_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      class_seen[out_trend_class]++;
      if (trend_expect_q.size() == 0) begin
        $error("unexpected result word: trend_class %0d window_fill %0d",
               out_trend_class, out_window_fill);
        fail_cnt++;
      end else begin
        w = trend_expect_q.pop_front();
        if (out_trend_class !== w.cls) begin
          $error("trend_class mismatch: expected %0d, got %0d", w.cls, out_trend_class);
          fail_cnt++;
        end
        if (out_window_fill !== w.fill) begin
          $error("window_fill mismatch: expected %0d, got %0d", w.fill, out_window_fill);
          fail_cnt++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("** sample_trend_classifier: FAILED **");
    $finish;
  end

  initial begin
    int          seg_thr [SEG_COUNT];
    int          seg_min [SEG_COUNT];
    pattern_t    pat;
    int          run_left;
    int          idx;
    int          noise_max;
    int          pick;
    longint      base;
    longint      slope;
    longint      v;
    logic [63:0] rnd64;
    logic [14:0] junk;
    logic [SAMPLE_W-1:0] smp;
    logic [THRESH_W-1:0] thr_data;
    dir_row_t    r;

    seg_thr = '{1024, 0, 1048575, 1, -1, 5000, -2, 1048575, 0};
    seg_min = '{5, 2, 20, 21, 1, 3, 0, 2, 20};
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_usage_sample <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_STABLE_THRESHOLD;
    cfg_data        <= '0;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    fail_cnt = 0;
    sent_cnt = 0;
    cfg_cnt  = 0;
    foreach (class_seen[i]) class_seen[i] = 0;
    foreach (ring_q[i]) ring_q[i] = '0;
    slot_q = 0;
    fill_q = 0;
    thr_q  = THRESH_RST;
    min_q  = MINS_RST;
    run_left = 0;
    idx = 0;
    pat = PAT_NOISE;
    base = 0;
    slope = 0;
    noise_max = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset defaults, too few samples, zero and unit threshold
    // on a flat window, minimum below two, minimum above the window (with
    // junk in the upper data bits), extremes, then filling and wrapping.
    add_sample(40'd0, 1'b1, CLS_UNKNOWN, 5'd1);
    add_sample(40'd0, 1'b1, CLS_UNKNOWN, 5'd2);
    add_cfg(CFG_STABLE_THRESHOLD, 20'd0);
    add_cfg(CFG_MIN_SAMPLES, 20'd0);
    add_sample(40'd0, 1'b1, CLS_DECLINING, 5'd3);
    add_cfg(CFG_STABLE_THRESHOLD, 20'd1);
    add_sample(40'd0, 1'b1, CLS_STABLE, 5'd4);
    add_cfg(CFG_MIN_SAMPLES, 20'd1);
    add_sample(40'hFF_FFFF_FFFF, 1'b0, CLS_UNKNOWN, 5'd0);
    add_sample(40'hFF_FFFF_FFFF, 1'b0, CLS_UNKNOWN, 5'd0);
    add_cfg(CFG_MIN_SAMPLES, 20'hFFFFF);
    add_sample(40'h55_5555_5555, 1'b1, CLS_UNKNOWN, 5'd7);
    add_cfg(CFG_MIN_SAMPLES, 20'd20);
    add_sample(40'hAA_AAAA_AAAA, 1'b1, CLS_UNKNOWN, 5'd8);
    add_cfg(CFG_STABLE_THRESHOLD, 20'hFFFFF);
    add_cfg(CFG_MIN_SAMPLES, 20'd2);
    for (int k = 0; k < 12; k++) add_sample(40'hFF_FFFF_FFFF - k * 3000000, 1'b0,
                                            CLS_UNKNOWN, 5'd0);
    add_cfg(CFG_STABLE_THRESHOLD, 20'd1024);
    for (int k = 0; k < 3; k++) add_sample(40'd1000 + k * 1024, 1'b0, CLS_UNKNOWN, 5'd0);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        wait_drained();
        write_reg(r.reg_idx, r.value[THRESH_W-1:0]);
      end else begin
        send_sample(r.value, r.typed, r.word);
      end
    end

    // Random segments: three idle profiles, each under three register settings
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct  = 8;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      wait_drained();
      if (seg_thr[seg] == -1) thr_data = 20'($urandom_range(0, 20'hFFFFF));
      else if (seg_thr[seg] == -2) thr_data = 20'($urandom_range(0, 4095));
      else thr_data = 20'(seg_thr[seg]);
      junk = 15'($urandom_range(0, 32767));
      write_reg(CFG_STABLE_THRESHOLD, thr_data);
      write_reg(CFG_MIN_SAMPLES, {junk, 5'(seg_min[seg])});

      for (int k = 0; k < SEG_WORDS; k++) begin
        // New run of samples: mostly straight lines with slope near the threshold
        if (run_left == 0) begin
          pick = $urandom_range(99);
          if (pick < 50) pat = PAT_LINE;
          else if (pick < 65) pat = PAT_FLAT;
          else if (pick < 85) pat = PAT_NOISE;
          else pat = PAT_EDGES;
          run_left = $urandom_range(8, 30);
          idx = 0;
          rnd64 = {$urandom, $urandom};
          if (pat == PAT_FLAT) base = longint'(rnd64[39:0]);
          else base = (64'sd1 <<< 39) + longint'(rnd64[29:0]);
          case ($urandom_range(4))
            0: slope = longint'(thr_q);
            1: slope = longint'(thr_q) - 1;
            2: slope = longint'(thr_q) + 1;
            3: slope = longint'($urandom_range(0, 2097152));
            default: slope = 0;
          endcase
          if ($urandom_range(1)) slope = -slope;
          noise_max = $urandom_range(1) ? 0 : $urandom_range(1, 7);
        end

        case (pat)
          PAT_LINE: begin
            v = base + slope * idx + longint'($urandom_range(0, noise_max));
            if (v < 0) smp = '0;
            else if (v > SAMPLE_MAX) smp = '1;
            else smp = v[SAMPLE_W-1:0];
          end
          PAT_FLAT: smp = base[SAMPLE_W-1:0];
          PAT_EDGES: smp = $urandom_range(1) ? '1 : '0;
          default: begin
            rnd64 = {$urandom, $urandom};
            smp = rnd64[SAMPLE_W-1:0];
          end
        endcase
        run_left--;
        idx++;

        // Occasionally let the pipe run dry before the next word
        if ($urandom_range(99) < 3) wait_drained();
        send_sample(smp, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);

    $display("Run covered %0d samples and %0d register writes", sent_cnt, cfg_cnt);
    $display("Results: unknown %0d, stable %0d, growing %0d, declining %0d",
             class_seen[CLS_UNKNOWN], class_seen[CLS_STABLE],
             class_seen[CLS_GROWING], class_seen[CLS_DECLINING]);
    if (fail_cnt == 0) begin
      $display("** sample_trend_classifier: PASSED **");
    end else begin
      $display("** sample_trend_classifier: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/stc_pkg.sv
src/stc_ctrl.sv
src/stc_dp.sv
src/sample_trend_classifier.sv
dv/tb_top.sv
